// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, off during reset
`define ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// ----- rtl/ttb_pkg.sv -----
// package with constants and types for the tangent / bitangent block
package ttb_pkg;
	localparam int POS_WIDTH_DEF = 16;
	localparam int UV_WIDTH_DEF  = 16;
	localparam int OUT_W         = 32;
	localparam int POS_FRAC      = 8;
	localparam int UV_FRAC       = 12;
	localparam int OUT_FRAC      = 16;
	localparam int QSHIFT        = OUT_FRAC + UV_FRAC - POS_FRAC;
	localparam int CNT_W         = 8;

	// controller commands to the datapath
	typedef struct packed {
		logic hold0;     // store vertex 0
		logic hold1;     // store vertex 1
		logic deltas;    // register edge deltas from vertex 2
		logic prod;      // multiply step, index in sel
		logic num;       // form numerator / det from products
		logic div_start; // load divider
		logic div_step;  // one quotient bit
		logic div_done;  // store quotient, index in sel
		logic [2:0] sel;
	} ttb_cmd_t;

	typedef struct packed {
		logic degen;
	} ttb_sts_t;
endpackage

// ----- rtl/ttb_ctrl.sv -----
// sequencer for vertex phases, products and serial division
module ttb_ctrl import ttb_pkg::*; #(
	parameter int DIV_STEPS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  logic     out_busy,
	input  logic     out_load_ok,
	input  ttb_sts_t sts,
	output logic     in_ready,
	output logic     out_load,
	output ttb_cmd_t cmd
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PROD = 6'b000010,
		S_NUM  = 6'b000100,
		S_DIV  = 6'b001000,
		S_NEXT = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	logic [1:0] phase_q;
	logic [2:0] idx_q;
	logic [CNT_W-1:0] cnt_q;

	assign in_ready = (state_q == S_IDLE) && !out_busy;

	always_comb begin
		cmd = '0;
		cmd.sel = idx_q;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.hold0 = in_fire && phase_q == 2'd0;
				cmd.hold1 = in_fire && phase_q == 2'd1;
				cmd.deltas = in_fire && phase_q == 2'd2;
			end
			S_PROD: cmd.prod = 1'b1;
			S_NUM: begin
				cmd.num = 1'b1;
				cmd.div_start = 1'b1;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_done = cnt_q == CNT_W'(DIV_STEPS - 1);
			end
			S_NEXT: ;
			S_OUT: out_load = out_load_ok;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= 2'd0;
			idx_q <= '0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					if (phase_q == 2'd2) begin
						phase_q <= 2'd0;
						idx_q <= '0;
						state_q <= S_PROD;
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end
				S_PROD: begin
					if (idx_q == 3'd6) begin
						idx_q <= '0;
						state_q <= S_NUM;
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
				S_NUM: begin
					cnt_q <= '0;
					state_q <= sts.degen ? S_OUT : S_DIV;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_q <= S_NEXT;
					else cnt_q <= cnt_q + CNT_W'(1);
				end
				S_NEXT: begin
					if (idx_q == 3'd5) begin
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + 3'd1;
						state_q <= S_NUM;
					end
				end
				S_OUT: if (out_load_ok) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/ttb_dp.sv -----
// datapath: held vertices, products, numerators, restoring divider
module ttb_dp import ttb_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	parameter int UV_WIDTH  = UV_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic signed [POS_WIDTH-1:0] pos_x,
	input  logic signed [POS_WIDTH-1:0] pos_y,
	input  logic signed [POS_WIDTH-1:0] pos_z,
	input  logic signed [UV_WIDTH-1:0]  tex_u,
	input  logic signed [UV_WIDTH-1:0]  tex_v,
	input  ttb_cmd_t                    cmd,
	output ttb_sts_t                    sts,
	output logic [6*OUT_W-1:0]          vec
);
	localparam int DPW = POS_WIDTH + 1;
	localparam int DUW = UV_WIDTH + 1;
	localparam int AW  = (DPW > DUW) ? DPW : DUW; // first multiplier operand
	localparam int PW  = AW + DUW;           // signed product width
	localparam int NW  = PW + 1;             // difference of products
	localparam int MW  = NW + QSHIFT;        // shifted numerator magnitude
	localparam int RW  = NW + 1;             // remainder

	logic signed [POS_WIDTH-1:0] p0_q [3];
	logic signed [POS_WIDTH-1:0] p1_q [3];
	logic signed [UV_WIDTH-1:0]  uv0_q [2];
	logic signed [UV_WIDTH-1:0]  uv1_q [2];
	logic signed [DPW-1:0] dp1_q [3];
	logic signed [DPW-1:0] dp2_q [3];
	logic signed [DUW-1:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [PW-1:0]  pr_q [14];
	logic signed [NW-1:0]  det_q;
	logic [NW-1:0] dmag_q;
	logic          neg_q;
	logic [MW-1:0] n_q;
	logic [RW-1:0] rem_q;
	logic [OUT_W:0] quo_q;
	logic [OUT_W-1:0] res_q [6];

	// product operands per step: 0..5 numerators, 6 determinant
	logic signed [AW-1:0]  ma, mc;
	logic signed [DUW-1:0] mb, md;
	always_comb begin
		ma = '0; mb = '0; mc = '0; md = '0;
		unique case (cmd.sel)
			3'd0, 3'd1, 3'd2: begin
				ma = AW'(dp1_q[cmd.sel[1:0]]); mb = dv2_q;
				mc = AW'(dp2_q[cmd.sel[1:0]]); md = dv1_q;
			end
			3'd3, 3'd4, 3'd5: begin
				ma = AW'(dp2_q[cmd.sel[1:0] - 2'd3]); mb = du1_q;
				mc = AW'(dp1_q[cmd.sel[1:0] - 2'd3]); md = du2_q;
			end
			3'd6: begin
				ma = AW'(du1_q); mb = dv2_q;
				mc = AW'(dv1_q); md = du2_q;
			end
			default: ;
		endcase
	end

	logic signed [NW-1:0] numer;
	logic [NW-1:0] nmag;
	logic [RW-1:0] rtry;
	logic [RW:0]   rsub;
	always_comb begin
		numer = NW'(pr_q[{cmd.sel, 1'b0}]) - NW'(pr_q[{cmd.sel, 1'b1}]);
		nmag  = numer[NW-1] ? NW'(-numer) : numer;
		rtry  = {rem_q[RW-2:0], n_q[MW-1]};
		rsub  = {1'b0, rtry} - (RW+1)'(dmag_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.hold0) begin
			p0_q[0] <= pos_x; p0_q[1] <= pos_y; p0_q[2] <= pos_z;
			uv0_q[0] <= tex_u; uv0_q[1] <= tex_v;
		end
		if (cmd.hold1) begin
			p1_q[0] <= pos_x; p1_q[1] <= pos_y; p1_q[2] <= pos_z;
			uv1_q[0] <= tex_u; uv1_q[1] <= tex_v;
		end
		if (cmd.deltas) begin
			dp1_q[0] <= DPW'(p1_q[0]) - DPW'(p0_q[0]);
			dp1_q[1] <= DPW'(p1_q[1]) - DPW'(p0_q[1]);
			dp1_q[2] <= DPW'(p1_q[2]) - DPW'(p0_q[2]);
			dp2_q[0] <= DPW'(pos_x) - DPW'(p0_q[0]);
			dp2_q[1] <= DPW'(pos_y) - DPW'(p0_q[1]);
			dp2_q[2] <= DPW'(pos_z) - DPW'(p0_q[2]);
			du1_q <= DUW'(uv1_q[0]) - DUW'(uv0_q[0]);
			dv1_q <= DUW'(uv1_q[1]) - DUW'(uv0_q[1]);
			du2_q <= DUW'(tex_u) - DUW'(uv0_q[0]);
			dv2_q <= DUW'(tex_v) - DUW'(uv0_q[1]);
		end
		if (cmd.prod) begin
			pr_q[{cmd.sel, 1'b0}] <= PW'(ma) * PW'(mb);
			pr_q[{cmd.sel, 1'b1}] <= PW'(mc) * PW'(md);
			if (cmd.sel == 3'd6) begin
				det_q  <= NW'(PW'(ma) * PW'(mb)) - NW'(PW'(mc) * PW'(md));
			end
		end
		if (cmd.sel == 3'd0 && cmd.num) begin
			dmag_q <= det_q[NW-1] ? NW'(-det_q) : det_q;
		end
		if (cmd.div_start) begin
			n_q   <= {nmag, QSHIFT'(0)};
			neg_q <= numer[NW-1] != det_q[NW-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			n_q <= {n_q[MW-2:0], 1'b0};
			if (!rsub[RW]) rem_q <= rsub[RW-1:0];
			else rem_q <= rtry;
			quo_q <= (quo_q[OUT_W] ? quo_q : {quo_q[OUT_W-1:0], !rsub[RW]});
		end
	end

	// saturate final quotient into the selected slot; a degenerate triangle zeroes all slots
	logic [OUT_W-1:0] qfin;
	logic [OUT_W:0]   qnext;
	always_comb begin
		qnext = quo_q[OUT_W] ? quo_q : {quo_q[OUT_W-1:0], !rsub[RW]};
		if (neg_q) begin
			qfin = (qnext > {2'b01, (OUT_W-1)'(0)}) ? {1'b1, (OUT_W-1)'(0)}
				: OUT_W'(-qnext);
		end else begin
			qfin = (qnext > {2'b00, {(OUT_W-1){1'b1}}}) ? {1'b0, {(OUT_W-1){1'b1}}}
				: qnext[OUT_W-1:0];
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.num && sts.degen) begin
			for (int i = 0; i < 6; i++) res_q[i] <= '0;
		end else if (cmd.div_done) begin
			res_q[cmd.sel] <= qfin;
		end
	end

	assign sts.degen = det_q == '0;
	assign vec = {res_q[5], res_q[4], res_q[3], res_q[2], res_q[1], res_q[0]};
endmodule

// ----- rtl/ttb_out.sv -----
// output register that replays one result three times
module ttb_out import ttb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [6*OUT_W-1:0] vec,
	input  logic               degen,
	input  logic               tready,
	output logic               tvalid,
	output logic               tlast,
	output logic [6*OUT_W-1:0] vec_q,
	output logic               degen_q,
	output logic               busy
);
	logic [1:0] left_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 2'd0;
		end else if (load) begin
			left_q <= 2'd3;
		end else if (tvalid && tready) begin
			left_q <= left_q - 2'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (load) begin
			vec_q <= vec;
			degen_q <= degen;
		end
	end
	assign tvalid = left_q != 2'd0;
	assign tlast  = left_q == 2'd1;
	assign busy   = tvalid;
endmodule

// ----- rtl/triangle_tangent_bitangent.sv -----
// top level of the triangle tangent / bitangent unit
//  channel | dir | contents
//  s_axis  | in  | one vertex word: pos_x, pos_y, pos_z, tex_u, tex_v
//  m_axis  | out | three result words per triangle, tlast on the third
// the first two vertices are only held; a third vertex starts 7 product steps,
// then 6 restoring divisions, each a setup, 55 quotient-bit steps and an advance,
// before the output load; a zero det skips the divisions and zeroes all slots;
// results are replayed three times from one output register, one word a cycle at
// best; new vertices wait until the replay is done; arst_n clears phase and control only
module triangle_tangent_bitangent import ttb_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	parameter int UV_WIDTH  = UV_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// pos_x, pos_y, pos_z, tex_u, tex_v from bit 0 up, zero filled
	input  logic [((3*POS_WIDTH+2*UV_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// tangent_x/y/z, bitangent_x/y/z from bit 0 up
	output logic [6*OUT_W-1:0] m_axis_tdata,
	// degenerate
	output logic m_axis_tuser,
	output logic m_axis_tlast
);
	`include "assert_macros.svh"
	// wider of the two delta widths, as used by the datapath multiplier
	localparam int OPW = (POS_WIDTH > UV_WIDTH) ? POS_WIDTH + 1 : UV_WIDTH + 1;
	// one divider step per bit of the shifted numerator magnitude
	localparam int DIV_STEPS = OPW + UV_WIDTH + 2 + QSHIFT;

	ttb_cmd_t cmd;
	ttb_sts_t sts;
	logic in_fire, out_load, out_busy;
	logic [6*OUT_W-1:0] vec;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	ttb_ctrl #(.DIV_STEPS(DIV_STEPS)) u_ctrl (
		.clk, .arst_n, .in_fire, .out_busy, .out_load_ok(!out_busy), .sts,
		.in_ready(s_axis_tready), .out_load, .cmd
	);

	ttb_dp #(.POS_WIDTH(POS_WIDTH), .UV_WIDTH(UV_WIDTH)) u_dp (
		.clk,
		.pos_x(s_axis_tdata[POS_WIDTH-1:0]),
		.pos_y(s_axis_tdata[2*POS_WIDTH-1:POS_WIDTH]),
		.pos_z(s_axis_tdata[3*POS_WIDTH-1:2*POS_WIDTH]),
		.tex_u(s_axis_tdata[3*POS_WIDTH+UV_WIDTH-1:3*POS_WIDTH]),
		.tex_v(s_axis_tdata[3*POS_WIDTH+2*UV_WIDTH-1:3*POS_WIDTH+UV_WIDTH]),
		.cmd, .sts, .vec
	);

	ttb_out u_out (
		.clk, .arst_n, .load(out_load), .vec, .degen(sts.degen),
		.tready(m_axis_tready), .tvalid(m_axis_tvalid), .tlast(m_axis_tlast),
		.vec_q(m_axis_tdata), .degen_q(m_axis_tuser), .busy(out_busy)
	);

	// no vertex taken while results are still being replayed
	`ASSERT_IMP(a_no_in_while_out, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	// a load always starts a fresh three-word burst
	`ASSERT_NXT(a_load_valid, clk, arst_n, out_load, m_axis_tvalid && !m_axis_tlast)
endmodule
